// ===== sv/lpls_pkg.sv =====
// Package for the light profile sampler: operation and profile codes, the
// pipeline control struct, fixed-point constants and the two pow ROMs.
// Used by every module of the block but lpls_ram; depends on nothing.
package lpls_pkg;

	localparam int MAX_TABLES_DEF    = 16;
	localparam int TABLE_SAMPLES_DEF = 32;
	localparam int ID_BASE_DEF       = 100;

	localparam logic [15:0] ONE_Q15 = 16'd32768;
	localparam logic [14:0] ONE_Q14 = 15'd16384;
	localparam logic [14:0] BAT_CENTER = 15'd7373;
	localparam logic [15:0] BAT_FLOOR = 16'd11469;
	// ceil(2^23 / 10): exact floor division by ten for operands below 2^22.
	localparam logic [19:0] RECIP10 = 20'd838861;
	localparam int RECIP_SH = 23;
	localparam int Q_W = 16;
	localparam int DVD_W = 40;
	localparam int DVS_W = 24;

	typedef enum logic [1:0] {
		FN_EVAL   = 2'd0,
		FN_WRITE  = 2'd1,
		FN_COMMIT = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_ROM45,
		KIND_ROM16,
		KIND_BAT,
		KIND_TABLE
	} kind_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [15:0] factor;
		logic [9:0]  tid;
		logic        full;
	} pipe_t;

	function automatic logic [15:0] rom_p45(input logic [4:0] k);
		logic [15:0] v;
		case (k)
			5'd0: v = 16'd0;
			5'd1: v = 16'd0;
			5'd2: v = 16'd3;
			5'd3: v = 16'd18;
			5'd4: v = 16'd64;
			5'd5: v = 16'd175;
			5'd6: v = 16'd397;
			5'd7: v = 16'd794;
			5'd8: v = 16'd1448;
			5'd9: v = 16'd2460;
			5'd10: v = 16'd3953;
			5'd11: v = 16'd6070;
			5'd12: v = 16'd8979;
			5'd13: v = 16'd12872;
			5'd14: v = 16'd17967;
			5'd15: v = 16'd24509;
			default: v = 16'd32768;
		endcase
		return v;
	endfunction

	function automatic logic [15:0] rom_p16(input logic [4:0] k);
		logic [15:0] v;
		case (k)
			5'd0: v = 16'd0;
			5'd1: v = 16'd388;
			5'd2: v = 16'd1176;
			5'd3: v = 16'd2250;
			5'd4: v = 16'd3566;
			5'd5: v = 16'd5096;
			5'd6: v = 16'd6822;
			5'd7: v = 16'd8730;
			5'd8: v = 16'd10809;
			5'd9: v = 16'd13051;
			5'd10: v = 16'd15447;
			5'd11: v = 16'd17992;
			5'd12: v = 16'd20680;
			5'd13: v = 16'd23505;
			5'd14: v = 16'd26464;
			5'd15: v = 16'd29553;
			default: v = 16'd32768;
		endcase
		return v;
	endfunction

endpackage

// ===== sv/light_profile_lut_sampler_unit.sv =====
// Light profile sampler: angular intensity factor from analytic profiles or
// registered candela tables. Depends on lpls_pkg, lpls_ram, lpls_analytic and
// lpls_div.
//
// Use: one input channel (in_valid/in_ready) carries an item with func and its
// fields; one output channel (out_valid/out_ready) returns exactly one result
// per item, in order. An evaluate gives factor; a commit gives table_id or
// registry_full; writes and clears return zeros.
// Throughput is one item per cycle while in_ready is high: the table path is a
// fixed pipeline (metadata RAM read, sample RAM reads, two multipliers, then
// a 16-stage divider, one quotient bit each). Table metadata and samples live
// in synchronous RAMs; writes happen at the same stage as the reads, so every
// access is seen in transaction order. Reset clears the table count and all
// valid bits; RAM contents are undefined until written. When the receiver
// stalls, a result waits in the output register and the pipeline keeps
// moving until a result reaches its last stage with the output register still
// full; in_ready then drops.
module light_profile_lut_sampler_unit
	import lpls_pkg::*;
#(
	parameter int MAX_TABLES    = MAX_TABLES_DEF,
	parameter int TABLE_SAMPLES = TABLE_SAMPLES_DEF,
	parameter int ID_BASE       = ID_BASE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic signed [15:0] cosine,
	input  logic signed [10:0] profile_id,
	input  logic [4:0]         sample_index,
	input  logic [23:0]        sample_value,
	input  logic [5:0]         table_length,
	input  logic [23:0]        peak_candela,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        factor,
	output logic [9:0]         table_id,
	output logic               registry_full
);
	localparam int SLOT_W  = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
	localparam int CNT_W   = $clog2(MAX_TABLES + 1);
	localparam int SDEPTH  = MAX_TABLES * TABLE_SAMPLES;
	localparam int SADDR_W = $clog2(SDEPTH);
	localparam int LEN_W   = $clog2(TABLE_SAMPLES + 1);
	localparam int IDX_W   = $clog2(TABLE_SAMPLES);
	localparam int POS_W   = 14 + IDX_W;
	localparam int PF_W    = 15 + LEN_W;
	localparam int META_W  = LEN_W + 24;

	logic en;
	logic [CNT_W-1:0] table_count_q;

	// Stage 1: the accepted transaction.
	logic               valid_s1;
	logic [1:0]         func_s1;
	logic [15:0]        cos_s1;
	logic [10:0]        id_s1;
	logic [4:0]         idx_s1;
	logic [23:0]        value_s1;
	logic [5:0]         tlen_s1;
	logic [23:0]        peak_s1;

	logic [14:0]        c1, u1;
	logic [9:0]         id_u;
	logic [10:0]        slot_full;
	pipe_t              p1;
	logic               meta_we, wr_ok;
	logic [CNT_W-1:0]   cnt_d;
	logic [LEN_W-1:0]   len_sat;
	logic [SADDR_W-1:0] waddr1;

	// Stage 2 and later.
	pipe_t              p_s2, p2, p_s3, p_s4, p4, p_s5;
	logic [14:0]        u_s2;
	logic [SLOT_W-1:0]  slot_s2, slot_s3;
	logic               wr_s2, wr_s3;
	logic [SADDR_W-1:0] waddr_s2, waddr_s3;
	logic [23:0]        wval_s2, wval_s3;
	logic [META_W-1:0]  meta_rd;
	logic [LEN_W-1:0]   len2, len_s3;
	logic [LEN_W-1:0]   lenm1;
	logic [PF_W-1:0]    pos_full;
	logic [POS_W-1:0]   pos_s3;
	logic [23:0]        peak_s3, peak_s4, peak_s5;
	logic [IDX_W-1:0]   i0, i1;
	logic [LEN_W-1:0]   i0p;
	logic [SADDR_W-1:0] base3, raddr_a, raddr_b;
	logic [13:0]        f_s4;
	logic [23:0]        sa, sb;
	logic [38:0]        pa_s5, pb_s5;
	logic [38:0]        num;
	logic [DVS_W-1:0]   pk;
	logic [DVD_W-1:0]   dvd;
	logic               ovf;
	logic [15:0]        ana_factor;

	pipe_t              p_last;
	logic [Q_W-1:0]     quo;
	logic               ovf_last;
	logic [15:0]        fac_fin;

	logic               out_valid_q;
	logic [15:0]        factor_q;
	logic [9:0]         tid_q;
	logic               full_q;

	// The pipeline moves unless a finished result would overrun a full output register.
	assign en       = !(out_valid_q && !out_ready && p_last.valid);
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1  <= func;
			cos_s1   <= cosine;
			id_s1    <= profile_id;
			idx_s1   <= sample_index;
			value_s1 <= sample_value;
			tlen_s1  <= table_length;
			peak_s1  <= peak_candela;
		end
	end

	always_comb begin
		if (cos_s1[15]) begin
			c1 = '0;
		end else if (cos_s1[14:0] > ONE_Q14) begin
			c1 = ONE_Q14;
		end else begin
			c1 = cos_s1[14:0];
		end
		u1        = ONE_Q14 - c1;
		id_u      = id_s1[9:0];
		slot_full = 11'(id_u) - 11'(ID_BASE);
		len_sat   = (32'(tlen_s1) > TABLE_SAMPLES) ? LEN_W'(TABLE_SAMPLES) : LEN_W'(tlen_s1);
		waddr1    = SADDR_W'(table_count_q[SLOT_W-1:0]) * SADDR_W'(TABLE_SAMPLES)
			+ SADDR_W'(idx_s1);
		p1        = '0;
		p1.valid  = valid_s1;
		p1.kind   = KIND_NONE;
		meta_we   = 1'b0;
		wr_ok     = 1'b0;
		cnt_d     = table_count_q;
		unique case (func_t'(func_s1))
			FN_EVAL: begin
				p1.factor = ONE_Q15;
				if (!id_s1[10] && id_u != 10'd0) begin
					if (id_u == 10'd1) begin
						p1.kind = KIND_ROM45;
					end else if (id_u == 10'd2) begin
						p1.kind = KIND_ROM16;
					end else if (id_u == 10'd3) begin
						p1.kind = KIND_BAT;
					end else if (11'(id_u) >= 11'(ID_BASE)
						&& slot_full < 11'(table_count_q)) begin
						p1.kind = KIND_TABLE;
					end
				end
			end
			FN_WRITE: begin
				wr_ok = (32'(table_count_q) < MAX_TABLES) && (32'(idx_s1) < TABLE_SAMPLES);
			end
			FN_COMMIT: begin
				if (32'(table_count_q) >= MAX_TABLES) begin
					p1.full = 1'b1;
				end else begin
					meta_we = 1'b1;
					p1.tid  = 10'(ID_BASE) + 10'(table_count_q);
					cnt_d   = table_count_q + CNT_W'(1);
				end
			end
			FN_CLEAR: begin
				cnt_d = '0;
			end
			default: begin
				cnt_d = table_count_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_count_q <= '0;
		end else if (en && valid_s1) begin
			table_count_q <= cnt_d;
		end
	end

	lpls_ram #(.WIDTH(META_W), .DEPTH(MAX_TABLES)) u_meta_ram (
		.clk   (clk),
		.we    (en && valid_s1 && meta_we),
		.waddr (table_count_q[SLOT_W-1:0]),
		.wdata ({len_sat, peak_s1}),
		.re    (en),
		.raddr (slot_full[SLOT_W-1:0]),
		.rdata (meta_rd)
	);

	lpls_analytic u_analytic (
		.clk    (clk),
		.en     (en),
		.c      (c1),
		.sel45  (p1.kind == KIND_ROM45),
		.is_bat (p1.kind == KIND_BAT),
		.factor (ana_factor)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_s2 <= '0;
			p_s3 <= '0;
			p_s4 <= '0;
			p_s5 <= '0;
		end else if (en) begin
			p_s2 <= p1;
			p_s3 <= p2;
			p_s4 <= p_s3;
			p_s5 <= p4;
		end
	end

	// Stage 2: metadata arrives; an empty table gives unity.
	always_comb begin
		len2  = meta_rd[META_W-1:24];
		lenm1 = len2 - LEN_W'(1);
		pos_full = PF_W'(u_s2) * PF_W'(lenm1);
		p2 = p_s2;
		if (p_s2.kind == KIND_TABLE && len2 == '0) begin
			p2.kind   = KIND_NONE;
			p2.factor = ONE_Q15;
		end
	end

	// Stage 3: sample addresses; sample writes land at this same stage.
	always_comb begin
		i0      = pos_s3[POS_W-1:14];
		i0p     = LEN_W'(i0) + LEN_W'(1);
		i1      = (i0p < len_s3) ? IDX_W'(i0p) : IDX_W'(len_s3 - LEN_W'(1));
		base3   = SADDR_W'(slot_s3) * SADDR_W'(TABLE_SAMPLES);
		raddr_a = base3 + SADDR_W'(i0);
		raddr_b = base3 + SADDR_W'(i1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s2     <= u1;
			slot_s2  <= slot_full[SLOT_W-1:0];
			wr_s2    <= wr_ok;
			waddr_s2 <= waddr1;
			wval_s2  <= value_s1;

			pos_s3   <= POS_W'(pos_full);
			len_s3   <= len2;
			peak_s3  <= meta_rd[23:0];
			slot_s3  <= slot_s2;
			wr_s3    <= wr_s2;
			waddr_s3 <= waddr_s2;
			wval_s3  <= wval_s2;

			f_s4     <= pos_s3[13:0];
			peak_s4  <= peak_s3;

			pa_s5    <= 39'(sa) * 39'(ONE_Q14 - 15'(f_s4));
			pb_s5    <= 39'(sb) * 39'(f_s4);
			peak_s5  <= peak_s4;
		end
	end

	lpls_ram #(.WIDTH(24), .DEPTH(SDEPTH)) u_sample_ram_a (
		.clk   (clk),
		.we    (en && p_s3.valid && wr_s3),
		.waddr (waddr_s3),
		.wdata (wval_s3),
		.re    (en),
		.raddr (raddr_a),
		.rdata (sa)
	);

	lpls_ram #(.WIDTH(24), .DEPTH(SDEPTH)) u_sample_ram_b (
		.clk   (clk),
		.we    (en && p_s3.valid && wr_s3),
		.waddr (waddr_s3),
		.wdata (wval_s3),
		.re    (en),
		.raddr (raddr_b),
		.rdata (sb)
	);

	// Stage 4: analytic results join the stream.
	always_comb begin
		p4 = p_s4;
		if (p_s4.kind == KIND_ROM45 || p_s4.kind == KIND_ROM16 || p_s4.kind == KIND_BAT) begin
			p4.factor = ana_factor;
		end
	end

	// Stage 5: rounded dividend 2*num + peak/2 and an early overflow test.
	always_comb begin
		num = pa_s5 + pb_s5;
		pk  = (peak_s5 == '0) ? DVS_W'(1) : peak_s5;
		dvd = {num, 1'b0} + DVD_W'(pk >> 1);
		ovf = dvd >= {pk, 16'd0};
	end

	lpls_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.pipe_in  (p_s5),
		.dvd      (dvd),
		.dvs      (pk),
		.ovf_in   (ovf),
		.pipe_out (p_last),
		.quo      (quo),
		.ovf_out  (ovf_last)
	);

	always_comb begin
		if (p_last.kind == KIND_TABLE) begin
			fac_fin = (ovf_last || quo > ONE_Q15) ? ONE_Q15 : quo;
		end else begin
			fac_fin = p_last.factor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			if (p_last.valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && p_last.valid) begin
			factor_q <= fac_fin;
			tid_q    <= p_last.tid;
			full_q   <= p_last.full;
		end
	end

	assign out_valid     = out_valid_q;
	assign factor        = factor_q;
	assign table_id      = tid_q;
	assign registry_full = full_q;
endmodule

// ===== sv/lpls_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; the read data holds while the read enable is low.
module lpls_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== sv/lpls_analytic.sv =====
// Analytic profiles: interpolated pow ROMs and the batwing shape, in three
// register stages from the clamped cosine. Depends on lpls_pkg.
module lpls_analytic (
	input  logic        clk,
	input  logic        en,
	input  logic [14:0] c,
	input  logic        sel45,
	input  logic        is_bat,
	output logic [15:0] factor
);
	import lpls_pkg::*;

	logic [14:0] u;
	logic [13:0] d;
	logic [4:0]  i0, i1;
	logic [15:0] ra, rb;
	logic [15:0] a_s2, rom_s3, rom_s4;
	logic [25:0] prod_s2;
	logic [18:0] x1_s2;
	logic [17:0] x2_s2;
	logic [15:0] q1_s3, q2_s3;
	logic [15:0] mid, w;
	logic [31:0] bat_s4;
	logic        bat_s2, bat_s3, bat_s4b;

	always_comb begin
		u  = ONE_Q14 - c;
		d  = (u >= BAT_CENTER) ? 14'(u - BAT_CENTER) : 14'(BAT_CENTER - u);
		i0 = c[14:10];
		i1 = (i0 < 5'd16) ? i0 + 5'd1 : 5'd16;
		ra = sel45 ? rom_p45(i0) : rom_p16(i0);
		rb = sel45 ? rom_p45(i1) : rom_p16(i1);
		mid = (q1_s3 >= ONE_Q15) ? 16'd0 : ONE_Q15 - q1_s3;
		w   = BAT_FLOOR + q2_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2    <= ra;
			prod_s2 <= 26'(rb - ra) * 26'(c[9:0]);
			x1_s2   <= 19'(d) * 19'd44 + 19'd5;
			x2_s2   <= 18'(c) * 18'd13 + 18'd5;
			bat_s2  <= is_bat;

			rom_s3 <= a_s2 + 16'((prod_s2 + 26'd512) >> 10);
			q1_s3  <= 16'((39'(x1_s2) * 39'(RECIP10)) >> RECIP_SH);
			q2_s3  <= 16'((38'(x2_s2) * 38'(RECIP10)) >> RECIP_SH);
			bat_s3 <= bat_s2;

			rom_s4  <= rom_s3;
			bat_s4  <= 32'(mid) * 32'(w);
			bat_s4b <= bat_s3;
		end
	end

	assign factor = bat_s4b ? 16'((bat_s4 + 32'd16384) >> 15) : rom_s4;
endmodule

// ===== sv/lpls_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for the table
// normalization. Carries the control struct alongside. Depends on lpls_pkg.
module lpls_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  lpls_pkg::pipe_t          pipe_in,
	input  logic [lpls_pkg::DVD_W-1:0] dvd,
	input  logic [lpls_pkg::DVS_W-1:0] dvs,
	input  logic                     ovf_in,
	output lpls_pkg::pipe_t          pipe_out,
	output logic [lpls_pkg::Q_W-1:0] quo,
	output logic                     ovf_out
);
	import lpls_pkg::*;

	pipe_t            pipe_q [Q_W+1];
	logic [DVS_W-1:0] rem_q  [Q_W+1];
	logic [DVS_W-1:0] dvs_q  [Q_W+1];
	logic [Q_W-1:0]   low_q  [Q_W+1];
	logic [Q_W-1:0]   quo_q  [Q_W+1];
	logic             ovf_q  [Q_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_q[0] <= '0;
		end else if (en) begin
			pipe_q[0] <= pipe_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= dvd[DVD_W-1:Q_W];
			low_q[0] <= dvd[Q_W-1:0];
			dvs_q[0] <= dvs;
			quo_q[0] <= '0;
			ovf_q[0] <= ovf_in;
		end
	end

	for (genvar k = 1; k <= Q_W; k++) begin : g_stage
		logic [DVS_W:0] trial;
		logic           ge;
		always_comb begin
			trial = {rem_q[k-1], low_q[k-1][Q_W-1]};
			ge    = trial >= {1'b0, dvs_q[k-1]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pipe_q[k] <= '0;
			end else if (en) begin
				pipe_q[k] <= pipe_q[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? DVS_W'(trial - {1'b0, dvs_q[k-1]}) : trial[DVS_W-1:0];
				low_q[k] <= low_q[k-1] << 1;
				quo_q[k] <= {quo_q[k-1][Q_W-2:0], ge};
				dvs_q[k] <= dvs_q[k-1];
				ovf_q[k] <= ovf_q[k-1];
			end
		end
	end

	assign pipe_out = pipe_q[Q_W];
	assign quo      = quo_q[Q_W];
	assign ovf_out  = ovf_q[Q_W];
endmodule

// ===== sv/lpls_chk.sv =====
// Port-level checker for the light profile sampler, bound to the top level.
// Depends on lpls_pkg and light_profile_lut_sampler_unit.
module lpls_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] factor,
	input logic [9:0]  table_id,
	input logic        registry_full
);
	import lpls_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(factor)
		&& $stable(table_id) && $stable(registry_full))
		else $error("output transaction changed while stalled");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input valid dropped before acceptance");

	a_factor_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> factor <= ONE_Q15)
		else $error("factor above unity");

	a_full_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && registry_full |-> factor == 16'd0 && table_id == 10'd0)
		else $error("refused commit carries a factor or an id");
endmodule

bind light_profile_lut_sampler_unit lpls_chk u_lpls_chk (.*);

// ===== sim/light_profile_lut_sampler_unit_tb.sv =====
// Self-checking testbench for light_profile_lut_sampler_unit: directed and random
// transactions against an in-bench predictor of the sampler, with bursty input and
// stalling output. Depends on lpls_pkg and the unit itself.
module light_profile_lut_sampler_unit_tb;
	import lpls_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 600000;
	localparam int ITEM_TARGET = 900;

	typedef struct {
		logic [15:0] factor;
		logic [9:0]  tid;
		logic        full;
	} sampler_result_t;

	localparam int unsigned POW45_ROM [17] = '{0, 0, 3, 18, 64, 175, 397, 794, 1448,
		2460, 3953, 6070, 8979, 12872, 17967, 24509, 32768};
	localparam int unsigned POW16_ROM [17] = '{0, 388, 1176, 2250, 3566, 5096, 6822,
		8730, 10809, 13051, 15447, 17992, 20680, 23505, 26464, 29553, 32768};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         func = FN_EVAL;
	logic signed [15:0] cosine = '0;
	logic signed [10:0] profile_id = '0;
	logic [4:0]         sample_index = '0;
	logic [23:0]        sample_value = '0;
	logic [5:0]         table_length = '0;
	logic [23:0]        peak_candela = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [15:0]        factor;
	logic [9:0]         table_id;
	logic               registry_full;

	light_profile_lut_sampler_unit dut (.*);

	always #5 clk = ~clk;

	// Predictor state.
	logic [23:0] cand_mem [512];
	bit          cand_written [512];
	logic [23:0] peak_mem [16];
	int unsigned len_mem [16];
	bit          slot_safe [16];
	int unsigned tab_count = 0;

	sampler_result_t expected_results [$];
	int  fail_count = 0;
	int  cycle_count = 0;
	int  item_count = 0;
	int  burst_left = 0;
	bit  no_gaps = 1'b0;
	int  hold_off = 0;
	int  stall_phase = 0;
	bit  stall_busy = 1'b0;

	function automatic int unsigned rom_interp(input bit use45, input int unsigned c);
		int unsigned i0, i1, a, b, fr;
		i0 = c >> 10;
		fr = c & 1023;
		i1 = (i0 < 16) ? i0 + 1 : 16;
		a = use45 ? POW45_ROM[i0] : POW16_ROM[i0];
		b = use45 ? POW45_ROM[i1] : POW16_ROM[i1];
		return a + (((b - a) * fr + 512) >> 10);
	endfunction

	function automatic int unsigned batwing_factor(input int unsigned c);
		int unsigned u, d, dip, mid, w;
		longint unsigned prod;
		u = 16384 - c;
		d = (u >= 7373) ? u - 7373 : 7373 - u;
		dip = (44 * d + 5) / 10;
		mid = (dip >= 32768) ? 0 : 32768 - dip;
		w = 11469 + (13 * c + 5) / 10;
		prod = longint'(mid) * w + 16384;
		return int'(prod >> 15);
	endfunction

	function automatic int unsigned table_factor(input int unsigned slot, input int unsigned c);
		int unsigned u, len, pos, i0, i1, f, pk;
		longint unsigned num, q;
		len = len_mem[slot];
		if (len == 0) return 32768;
		u = 16384 - c;
		pos = u * (len - 1);
		i0 = pos >> 14;
		f = pos & 16383;
		if (i0 > len - 1) i0 = len - 1;
		i1 = (i0 + 1 < len) ? i0 + 1 : len - 1;
		num = longint'(cand_mem[slot * 32 + i0]) * (16384 - f)
			+ longint'(cand_mem[slot * 32 + i1]) * f;
		pk = (peak_mem[slot] == 0) ? 1 : peak_mem[slot];
		q = (2 * num + (pk >> 1)) / pk;
		return (q > 32768) ? 32768 : int'(q);
	endfunction

	function automatic sampler_result_t light_factor_predict(input logic [1:0] fn,
		input logic signed [15:0] c_in, input logic signed [10:0] pid,
		input logic [4:0] idx, input logic [23:0] val, input logic [5:0] tl,
		input logic [23:0] pk);
		sampler_result_t r;
		int unsigned c, len;
		r.factor = '0;
		r.tid = '0;
		r.full = 1'b0;
		case (fn)
			FN_EVAL: begin
				if (c_in < 0) c = 0;
				else if (c_in > 16384) c = 16384;
				else c = c_in;
				if (pid <= 0) r.factor = 16'd32768;
				else if (pid == 1) r.factor = 16'(rom_interp(1'b1, c));
				else if (pid == 2) r.factor = 16'(rom_interp(1'b0, c));
				else if (pid == 3) r.factor = 16'(batwing_factor(c));
				else if (pid >= 100 && (pid - 100) < tab_count)
					r.factor = 16'(table_factor(pid - 100, c));
				else r.factor = 16'd32768;
			end
			FN_WRITE: begin
				if (tab_count < 16) begin
					cand_mem[tab_count * 32 + idx] = val;
					cand_written[tab_count * 32 + idx] = 1'b1;
				end
			end
			FN_COMMIT: begin
				if (tab_count >= 16) begin
					r.full = 1'b1;
				end else begin
					len = (tl > 32) ? 32 : tl;
					len_mem[tab_count] = len;
					peak_mem[tab_count] = pk;
					slot_safe[tab_count] = 1'b1;
					for (int k = 0; k < len; k++)
						if (!cand_written[tab_count * 32 + k]) slot_safe[tab_count] = 1'b0;
					r.tid = 10'(100 + tab_count);
					tab_count++;
				end
			end
			default: tab_count = 0;
		endcase
		return r;
	endfunction

	// Entered and left at a falling edge; in_valid stays high between back-to-back items.
	task automatic send_item(input func_t fn, input logic signed [15:0] c,
		input logic signed [10:0] pid, input logic [4:0] idx, input logic [23:0] val,
		input logic [5:0] tl, input logic [23:0] pk);
		bit hs;
		if (!no_gaps) begin
			if (burst_left == 0) begin
				if ($urandom_range(0, 2) != 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 12)) @(negedge clk);
				end
				burst_left = $urandom_range(1, 40);
			end
			burst_left--;
		end
		func <= fn;
		cosine <= c;
		profile_id <= pid;
		sample_index <= idx;
		sample_value <= val;
		table_length <= tl;
		peak_candela <= pk;
		in_valid <= 1'b1;
		do begin
			@(posedge clk);
			hs = in_ready;
			if (hs) begin
				expected_results.insert(expected_results.size(),
					light_factor_predict(fn, c, pid, idx, val, tl, pk));
				item_count++;
			end
			@(negedge clk);
		end while (!hs);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		wait (expected_results.size() == 0);
		repeat (30) @(negedge clk);
	endtask

	task automatic eval_item(input logic signed [10:0] pid, input logic signed [15:0] c);
		send_item(FN_EVAL, c, pid, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic write_item(input logic [4:0] idx, input logic [23:0] val);
		send_item(FN_WRITE, $urandom, $urandom, idx, val, $urandom, $urandom);
	endtask

	task automatic commit_item(input logic [5:0] tl, input logic [23:0] pk);
		send_item(FN_COMMIT, $urandom, $urandom, $urandom, $urandom, tl, pk);
	endtask

	task automatic clear_item();
		send_item(FN_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic fill_all_samples();
		for (int k = 0; k < 32; k++) write_item(k, $urandom);
	endtask

	function automatic logic signed [15:0] pick_cos();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 16'sd16384;
			2: return 16'sd0;
			default: return $urandom_range(0, 16384);
		endcase
	endfunction

	function automatic logic signed [10:0] pick_profile();
		int s;
		case ($urandom_range(0, 9))
			0, 1: return $urandom_range(1, 3);
			2, 3, 4, 5: begin
				for (int t = 0; t < 8; t++) begin
					s = $urandom_range(0, 15);
					if (s < tab_count && slot_safe[s]) return 100 + s;
				end
				return $urandom_range(1, 3);
			end
			6: return 100 + tab_count + $urandom_range(0, 923 - tab_count);
			7: return -$urandom_range(0, 1024);
			8: return $urandom_range(4, 99);
			default: return $urandom_range(100, 115) < 100 + tab_count ? 1 : 1023;
		endcase
	endfunction

	task automatic test_analytic_profiles();
		eval_item(1, 16'sd0);
		eval_item(1, 16'sd16384);
		eval_item(1, 16'sd9000);
		eval_item(2, 16'sd5555);
		eval_item(2, -16'sd32768);
		eval_item(2, 16'sd32767);
		eval_item(3, 16'sd0);
		eval_item(3, 16'sd16384);
		eval_item(3, 16'sd9011);
		eval_item(0, 16'sd8000);
		eval_item(-11'sd1024, 16'sd8000);
		eval_item(11'sd50, 16'sd8000);
		eval_item(11'sd1023, 16'sd8000);
		eval_item(11'sd100, 16'sd8000);
	endtask

	task automatic test_table_build();
		write_item(5'd0, 24'd0);
		write_item(5'd31, 24'hFFFFFF);
		fill_all_samples();
		commit_item(6'd63, 24'd0);
		eval_item(100, 16'sd0);
		eval_item(100, 16'sd16384);
		eval_item(100, 16'sd4321);
		commit_item(6'd0, 24'hFFFFFF);
		eval_item(101, 16'sd777);
		write_item(5'd0, 24'd5000);
		commit_item(6'd1, 24'hFFFFFF);
		eval_item(102, 16'sd777);
		fill_all_samples();
		commit_item(6'd32, 24'hFFFFFF);
		eval_item(103, 16'sd12000);
	endtask

	task automatic test_registry_full();
		while (tab_count < 16) begin
			fill_all_samples();
			commit_item($urandom_range(0, 40), $urandom_range(1, 24'hFFFFFF));
		end
		write_item(5'd3, 24'h123456);
		commit_item(6'd5, 24'd100);
		eval_item(115, 16'sd3000);
		eval_item(116, 16'sd3000);
		clear_item();
		eval_item(100, 16'sd3000);
	endtask

	task automatic test_backpressure();
		drain_results();
		hold_off = 400;
		no_gaps = 1'b1;
		for (int k = 0; k < 80; k++) eval_item(pick_profile(), pick_cos());
		no_gaps = 1'b0;
		drain_results();
	endtask

	task automatic test_random_traffic();
		while (item_count < ITEM_TARGET) begin
			case ($urandom_range(0, 19))
				0: clear_item();
				1, 2: commit_item(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom);
				3, 4, 5, 6: write_item($urandom, $urandom);
				7: begin
					fill_all_samples();
					commit_item($urandom_range(2, 33), $urandom);
				end
				default: eval_item(pick_profile(), pick_cos());
			endcase
			if ($urandom_range(0, 299) == 0) drain_results();
		end
	endtask

	// Receiver: stalls during hold_off, then alternates ready and stalling stretches.
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else begin
			if (stall_phase == 0) begin
				stall_phase <= $urandom_range(20, 200);
				stall_busy <= $urandom_range(0, 1);
			end else begin
				stall_phase <= stall_phase - 1;
			end
			out_ready <= stall_busy ? ($urandom_range(0, 9) < 6) : 1'b1;
		end
	end

	always @(posedge clk) begin
		sampler_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result factor=%0d table_id=%0d registry_full=%0d",
					factor, table_id, registry_full);
				fail_count++;
			end else begin
				e = expected_results.pop_front();
				if (factor !== e.factor) begin
					$error("factor: expected %0d, got %0d", e.factor, factor);
					fail_count++;
				end
				if (table_id !== e.tid) begin
					$error("table_id: expected %0d, got %0d", e.tid, table_id);
					fail_count++;
				end
				if (registry_full !== e.full) begin
					$error("registry_full: expected %0d, got %0d", e.full, registry_full);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("light_profile_lut_sampler_unit regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_analytic_profiles();
		test_table_build();
		test_registry_full();
		test_backpressure();
		test_random_traffic();
		in_valid <= 1'b0;
		wait (expected_results.size() == 0);
		repeat (40) @(negedge clk);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("light_profile_lut_sampler_unit regression: pass");
		end else begin
			$display("light_profile_lut_sampler_unit regression: fail");
		end
		$finish;
	end

endmodule
